// ===== rtl/ffha_pkg.sv =====
package ffha_pkg;

   localparam int HEAP_BYTES   = 1024;
   localparam int HEADER_BYTES = 24;
   localparam int GRAN_BYTES   = 8;
   localparam int NGRAN        = HEAP_BYTES / GRAN_BYTES;
   localparam int IDX_W        = $clog2(NGRAN);
   localparam int BYTES_W      = 11;
   localparam int HDR_GRAN     = HEADER_BYTES / GRAN_BYTES;
   localparam int INIT_BYTES   = ((HEAP_BYTES - HEADER_BYTES) + 7) / 8 * 8;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_NOFIT   = 3'd1,
      ST_RANGE   = 3'd2,
      ST_ALIGN   = 3'd3,
      ST_NOTUSED = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_RUN,
      FSM_HOLD
   } fsm_type;

   // request token walking the cell chain
   typedef struct packed {
      logic               valid;
      logic               op;
      logic [BYTES_W-1:0] size;
      logic [IDX_W-1:0]   target;
      logic               done;
      status_type         status;
      logic [BYTES_W-1:0] goff;
      logic [BYTES_W-1:0] gbytes;
      logic               wr_en;
      logic [IDX_W-1:0]   wr_idx;
      logic [BYTES_W-1:0] wr_bytes;
      logic               prev_free;
      logic [IDX_W-1:0]   prev_idx;
      logic [BYTES_W-1:0] prev_bytes;
      logic               merge_pending;
   } tok_type;

   // header write broadcast to all cells once a token leaves the chain
   typedef struct packed {
      logic               en;
      logic [IDX_W-1:0]   idx;
      logic [BYTES_W-1:0] bytes;
   } wr_type;

endpackage

// ===== rtl/first_fit_heap_allocator.sv =====
// channel | direction | handshake               | payload
// req     | in        | req_tvalid / req_tready | tuser op, tdata req_bytes, user_offset
// rsp     | out       | rsp_tvalid / rsp_tready | tdata status, granted_offset, granted_bytes
//
// An allocate, or a free that passes the range and alignment checks, sends one token
// through the row of granule cells, one cell per cycle.
// Range and alignment errors skip the walk.
// Reset is synchronous; the heap returns to one free block at offset 0.
// A stalled rsp side holds the finished word; a new request is taken once the walk is idle.
module first_fit_heap_allocator
   import ffha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [9:0] req_bytes, [19:10] user_offset, rest zero
   input  logic [0:0]  req_tuser,   // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [2:0] status, [12:3] granted_offset,
                                    // [22:13] granted_bytes, rest zero
);

   fsm_type            state_ff, state_in;
   tok_type            tok_ff, tok_in;
   tok_type            chain [0:NGRAN];
   wr_type             wr;
   status_type         pend_status_ff, pend_status_in;
   logic [9:0]         pend_goff_ff, pend_goff_in;
   logic [9:0]         pend_bytes_ff, pend_bytes_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [23:0]        rsp_data_ff, rsp_data_in;

   logic               accept, bad_range, bad_align, start;
   logic [9:0]         req_bytes, user_offset;
   logic [9:0]         tgt_bytes;
   logic               rsp_free;

   assign req_bytes   = req_tdata[9:0];
   assign user_offset = req_tdata[19:10];
   assign accept      = req_tvalid && req_tready;
   assign bad_range   = ({1'b0, user_offset} < 11'(HEADER_BYTES))
                        || ({1'b0, user_offset} >= 11'(HEAP_BYTES));
   assign bad_align   = (user_offset[2:0] != 3'b000);
   assign start       = accept && ((req_tuser[0] == OP_ALLOC) || (!bad_range && !bad_align));
   assign tgt_bytes   = user_offset - 10'(HEADER_BYTES);
   assign rsp_free    = !rsp_valid_ff || rsp_tready;

   // chain of granule cells
   assign chain[0] = tok_ff;
   assign wr.en    = chain[NGRAN].valid && chain[NGRAN].wr_en;
   assign wr.idx   = chain[NGRAN].wr_idx;
   assign wr.bytes = chain[NGRAN].wr_bytes;

   for (genvar g = 0; g < NGRAN; g++) begin : g_cell
      ffha_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (IDX_W'(g)),
         .wr       (wr),
         .tok_in   (chain[g]),
         .tok_out  (chain[g+1])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: if (accept) begin
            state_in = start ? FSM_RUN : FSM_HOLD;
         end
         FSM_RUN: if (chain[NGRAN].valid) begin
            state_in = FSM_HOLD;
         end
         FSM_HOLD: if (rsp_free) begin
            state_in = FSM_IDLE;
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_tready     = (state_ff == FSM_IDLE);
      tok_in         = '0;
      pend_status_in = pend_status_ff;
      pend_goff_in   = pend_goff_ff;
      pend_bytes_in  = pend_bytes_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      unique case (state_ff)
         FSM_IDLE: if (accept) begin
            tok_in.valid  = start;
            tok_in.op     = req_tuser[0];
            tok_in.size   = ({1'b0, req_bytes} + 11'd7) & ~11'd7;
            tok_in.target = tgt_bytes[IDX_W+2:3];
            tok_in.status = (req_tuser[0] == OP_ALLOC) ? ST_NOFIT : ST_NOTUSED;
            pend_status_in = bad_range ? ST_RANGE : ST_ALIGN;
            pend_goff_in   = '0;
            pend_bytes_in  = '0;
         end
         FSM_RUN: if (chain[NGRAN].valid) begin
            pend_status_in = chain[NGRAN].status;
            pend_goff_in   = (chain[NGRAN].op == OP_ALLOC) ? chain[NGRAN].goff[9:0] : '0;
            pend_bytes_in  = chain[NGRAN].gbytes[9:0];
         end
         FSM_HOLD: if (rsp_free) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {1'b0, pend_bytes_ff, pend_goff_ff, pend_status_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         tok_ff.valid <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tok_ff       <= tok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_status_ff <= pend_status_in;
      pend_goff_ff   <= pend_goff_in;
      pend_bytes_ff  <= pend_bytes_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/ffha_cell.sv =====
module ffha_cell
   import ffha_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] cell_idx,
   input  wr_type           wr,
   input  tok_type          tok_in,
   output tok_type          tok_out
);

   logic               present_ff, present_in;
   logic               free_ff, free_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;
   tok_type            tok_ff, tok_nx;
   logic [11:0]        split_need;
   logic [7:0]         split_idx;

   assign split_need = {1'b0, tok_in.size} + 12'(HEADER_BYTES + GRAN_BYTES);
   assign split_idx  = {1'b0, cell_idx} + 8'(HDR_GRAN) + 8'(tok_in.size >> 3);

   always_comb begin
      tok_nx     = tok_in;
      present_in = present_ff;
      free_in    = free_ff;
      bytes_in   = bytes_ff;
      if (wr.en && wr.idx == cell_idx) begin
         present_in = 1'b1;
         free_in    = 1'b1;
         bytes_in   = wr.bytes;
      end else if (tok_in.valid) begin
         if (tok_in.op == OP_ALLOC) begin
            if (present_ff && !tok_in.done && free_ff && bytes_ff >= tok_in.size) begin
               tok_nx.done   = 1'b1;
               tok_nx.status = ST_OK;
               tok_nx.goff   = {1'b0, cell_idx, 3'b000} + BYTES_W'(HEADER_BYTES);
               free_in       = 1'b0;
               if ({1'b0, bytes_ff} >= split_need) begin
                  bytes_in        = tok_in.size;
                  tok_nx.gbytes   = tok_in.size;
                  tok_nx.wr_en    = 1'b1;
                  tok_nx.wr_idx   = split_idx[IDX_W-1:0];
                  tok_nx.wr_bytes = bytes_ff - tok_in.size - BYTES_W'(HEADER_BYTES);
               end else begin
                  tok_nx.gbytes = bytes_ff;
               end
            end
         end else if (!tok_in.done) begin
            if (cell_idx == tok_in.target) begin
               tok_nx.done = 1'b1;
               if (present_ff && !free_ff) begin
                  tok_nx.status        = ST_OK;
                  tok_nx.gbytes        = bytes_ff;
                  tok_nx.wr_en         = 1'b1;
                  tok_nx.merge_pending = 1'b1;
                  if (tok_in.prev_free) begin
                     // fold into the free block in front
                     tok_nx.wr_idx   = tok_in.prev_idx;
                     tok_nx.wr_bytes = tok_in.prev_bytes + bytes_ff
                                       + BYTES_W'(HEADER_BYTES);
                     present_in      = 1'b0;
                     free_in         = 1'b0;
                     bytes_in        = '0;
                  end else begin
                     tok_nx.wr_idx   = cell_idx;
                     tok_nx.wr_bytes = bytes_ff;
                     free_in         = 1'b1;
                  end
               end
            end else if (present_ff) begin
               tok_nx.prev_free  = free_ff;
               tok_nx.prev_idx   = cell_idx;
               tok_nx.prev_bytes = bytes_ff;
            end
         end else if (tok_in.merge_pending && present_ff) begin
            tok_nx.merge_pending = 1'b0;
            if (free_ff) begin
               tok_nx.wr_bytes = tok_in.wr_bytes + bytes_ff + BYTES_W'(HEADER_BYTES);
               present_in      = 1'b0;
               free_in         = 1'b0;
               bytes_in        = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff   <= (cell_idx == '0);
         free_ff      <= (cell_idx == '0);
         bytes_ff     <= (cell_idx == '0) ? BYTES_W'(INIT_BYTES) : '0;
         tok_ff.valid <= 1'b0;
      end else begin
         present_ff <= present_in;
         free_ff    <= free_in;
         bytes_ff   <= bytes_in;
         tok_ff     <= tok_nx;
      end
   end

   assign tok_out = tok_ff;

endmodule
